@@ rtl/lds_pkg.sv @@
package lds_pkg;

   localparam int CFG_BITS      = 12;
   localparam int INTERVAL_BITS = 16;
   localparam int CLASS_BITS    = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int DIR_BITS      = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_REF_X        = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REF_Y        = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEADZONE_H   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEADZONE_V   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_INTERVAL = 3'd4;

   localparam logic [CFG_BITS-1:0]      REF_X_RESET        = 12'd960;
   localparam logic [CFG_BITS-1:0]      REF_Y_RESET        = 12'd540;
   localparam logic [CFG_BITS-1:0]      DEADZONE_H_RESET   = 12'd150;
   localparam logic [CFG_BITS-1:0]      DEADZONE_V_RESET   = 12'd100;
   localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RESET = 16'd100;

   localparam logic [DIR_BITS-1:0] DIR_LEFT  = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_UP    = 2'd2;
   localparam logic [DIR_BITS-1:0] DIR_DOWN  = 2'd3;

   localparam logic                  ACTION_BOX   = 1'b0;
   localparam logic                  ACTION_TICK  = 1'b1;
   localparam logic [CLASS_BITS-1:0] CLASS_PERSON = 8'd0;

   typedef struct packed {
      logic [CFG_BITS-1:0]      ref_x;
      logic [CFG_BITS-1:0]      ref_y;
      logic [CFG_BITS-1:0]      deadzone_horizontal;
      logic [CFG_BITS-1:0]      deadzone_vertical;
      logic [INTERVAL_BITS-1:0] min_interval_ticks;
   } lds_cfg_type;

   typedef struct packed {
      logic                hit;
      logic [DIR_BITS-1:0] dir;
   } lds_decision_type;

endpackage

@@ rtl/lds_csr.sv @@
module lds_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [lds_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [lds_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output lds_pkg::lds_cfg_type                  cfg
);

   lds_pkg::lds_cfg_type cfg_ff;
   lds_pkg::lds_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lds_pkg::CSR_REF_X:
               cfg_in.ref_x = csr_data[lds_pkg::CFG_BITS-1:0];
            lds_pkg::CSR_REF_Y:
               cfg_in.ref_y = csr_data[lds_pkg::CFG_BITS-1:0];
            lds_pkg::CSR_DEADZONE_H:
               cfg_in.deadzone_horizontal = csr_data[lds_pkg::CFG_BITS-1:0];
            lds_pkg::CSR_DEADZONE_V:
               cfg_in.deadzone_vertical = csr_data[lds_pkg::CFG_BITS-1:0];
            lds_pkg::CSR_MIN_INTERVAL:
               cfg_in.min_interval_ticks = csr_data[lds_pkg::INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_x               <= lds_pkg::REF_X_RESET;
         cfg_ff.ref_y               <= lds_pkg::REF_Y_RESET;
         cfg_ff.deadzone_horizontal <= lds_pkg::DEADZONE_H_RESET;
         cfg_ff.deadzone_vertical   <= lds_pkg::DEADZONE_V_RESET;
         cfg_ff.min_interval_ticks  <= lds_pkg::MIN_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/lds_core.sv @@
module lds_core #(
   parameter int COORD_BITS = 12,
   parameter int TICK_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  lds_pkg::lds_cfg_type                cfg,
   input  logic                                action,
   input  logic [lds_pkg::CLASS_BITS-1:0]      object_class,
   input  logic [COORD_BITS-1:0]               box_left,
   input  logic [COORD_BITS-1:0]               box_top,
   input  logic [COORD_BITS-1:0]               box_width,
   input  logic [COORD_BITS-1:0]               box_height,
   input  logic                                last_in_frame,
   output logic                                emit,
   output logic [lds_pkg::DIR_BITS-1:0]        direction
);

   localparam int AREA_BITS = 2 * COORD_BITS;
   localparam int SUM_BITS  =
      ((COORD_BITS + 2 > lds_pkg::CFG_BITS + 2) ? COORD_BITS + 2 : lds_pkg::CFG_BITS + 2) + 1;
   localparam int CMP_BITS  =
      (TICK_BITS > lds_pkg::INTERVAL_BITS) ? TICK_BITS : lds_pkg::INTERVAL_BITS;
   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

   logic [AREA_BITS-1:0]  best_area_ff,   best_area_in;
   logic [COORD_BITS-1:0] best_left_ff,   best_left_in;
   logic [COORD_BITS-1:0] best_top_ff,    best_top_in;
   logic [COORD_BITS-1:0] best_width_ff,  best_width_in;
   logic [COORD_BITS-1:0] best_height_ff, best_height_in;
   logic                  have_person_ff, have_person_in;
   logic [TICK_BITS-1:0]  ticks_ff,       ticks_in;

   logic                  is_tick;
   logic                  person;
   logic                  take_new;
   logic                  end_frame;
   logic                  interval_met;
   logic                  decide_now;
   logic [AREA_BITS-1:0]  area;
   lds_pkg::lds_decision_type dec_new;
   lds_pkg::lds_decision_type dec_old;
   lds_pkg::lds_decision_type dec_sel;

   // centres doubled so the half pixel stays exact
   function automatic lds_pkg::lds_decision_type decide(
      input logic [COORD_BITS-1:0] l,
      input logic [COORD_BITS-1:0] t,
      input logic [COORD_BITS-1:0] w,
      input logic [COORD_BITS-1:0] h,
      input lds_pkg::lds_cfg_type  c
   );
      logic [SUM_BITS-1:0] cx2;
      logic [SUM_BITS-1:0] cy2;
      logic [SUM_BITS-1:0] rx2;
      logic [SUM_BITS-1:0] ry2;
      logic [SUM_BITS-1:0] dx2;
      logic [SUM_BITS-1:0] dy2;
      lds_pkg::lds_decision_type d;
      cx2 = (SUM_BITS'(l) << 1) + SUM_BITS'(w);
      cy2 = (SUM_BITS'(t) << 1) + SUM_BITS'(h);
      rx2 = SUM_BITS'(c.ref_x) << 1;
      ry2 = SUM_BITS'(c.ref_y) << 1;
      dx2 = SUM_BITS'(c.deadzone_horizontal) << 1;
      dy2 = SUM_BITS'(c.deadzone_vertical) << 1;
      d.hit = 1'b1;
      d.dir = lds_pkg::DIR_LEFT;
      if (cx2 > rx2 + dx2) begin
         d.dir = lds_pkg::DIR_RIGHT;
      end else if (cx2 + dx2 < rx2) begin
         d.dir = lds_pkg::DIR_LEFT;
      end else if (cy2 + dy2 < ry2) begin
         d.dir = lds_pkg::DIR_UP;
      end else if (cy2 > ry2 + dy2) begin
         d.dir = lds_pkg::DIR_DOWN;
      end else begin
         d.hit = 1'b0;
      end
      return d;
   endfunction

   assign is_tick      = (action == lds_pkg::ACTION_TICK);
   assign person       = !is_tick && (object_class == lds_pkg::CLASS_PERSON);
   assign area         = AREA_BITS'(box_width) * AREA_BITS'(box_height);
   assign take_new     = person && (!have_person_ff || area > best_area_ff);
   assign end_frame    = !is_tick && last_in_frame;
   assign interval_met = CMP_BITS'(ticks_ff) >= CMP_BITS'(cfg.min_interval_ticks);
   assign decide_now   = end_frame && (have_person_ff || person) && interval_met;

   assign dec_new = decide(box_left, box_top, box_width, box_height, cfg);
   assign dec_old = decide(best_left_ff, best_top_ff, best_width_ff, best_height_ff, cfg);
   assign dec_sel = take_new ? dec_new : dec_old;

   assign emit      = fire && decide_now && dec_sel.hit;
   assign direction = dec_sel.dir;

   always_comb begin
      best_area_in   = best_area_ff;
      best_left_in   = best_left_ff;
      best_top_in    = best_top_ff;
      best_width_in  = best_width_ff;
      best_height_in = best_height_ff;
      have_person_in = have_person_ff;
      ticks_in       = ticks_ff;
      if (fire) begin
         if (is_tick) begin
            if (ticks_ff != TICK_MAX) begin
               ticks_in = ticks_ff + TICK_BITS'(1);
            end
         end else begin
            if (take_new) begin
               best_area_in   = area;
               best_left_in   = box_left;
               best_top_in    = box_top;
               best_width_in  = box_width;
               best_height_in = box_height;
               have_person_in = 1'b1;
            end
            if (decide_now) begin
               ticks_in = '0;
            end
            if (end_frame) begin
               best_area_in   = '0;
               have_person_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_area_ff   <= '0;
         have_person_ff <= 1'b0;
         ticks_ff       <= '0;
      end else begin
         best_area_ff   <= best_area_in;
         have_person_ff <= have_person_in;
         ticks_ff       <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      best_left_ff   <= best_left_in;
      best_top_ff    <= best_top_in;
      best_width_ff  <= best_width_in;
      best_height_ff <= best_height_in;
   end

endmodule

@@ rtl/largest_box_deadzone_steering.sv @@
// Person tracker and steering: takes one box or one tick per clock unless a
// result waits on a stalled output, keeps the largest person box of each
// frame and, at the frame's last box, issues left, right, up or down when the
// box centre lies outside the deadzone and enough ticks have passed since the
// last decision. Throughput is one item every cycle under that condition; the
// last box of a frame goes from the input register through the area multiply
// and centre compares into the result register. The input side stalls only
// while its register is full and a result waits on a stalled output.
module largest_box_deadzone_steering #(
   parameter int COORD_BITS = 12,
   parameter int TICK_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [lds_pkg::CLASS_BITS-1:0]    req_object_class,
   input  logic [COORD_BITS-1:0]             req_box_left,
   input  logic [COORD_BITS-1:0]             req_box_top,
   input  logic [COORD_BITS-1:0]             req_box_width,
   input  logic [COORD_BITS-1:0]             req_box_height,
   input  logic                              req_last_in_frame,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lds_pkg::DIR_BITS-1:0]      rsp_direction,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lds_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lds_pkg::CSR_DATA_BITS-1:0] csr_data
);

   lds_pkg::lds_cfg_type cfg;

   logic                           in_v_ff, in_v_in;
   logic                           action_ff;
   logic [lds_pkg::CLASS_BITS-1:0] class_ff;
   logic [COORD_BITS-1:0]          left_ff;
   logic [COORD_BITS-1:0]          top_ff;
   logic [COORD_BITS-1:0]          width_ff;
   logic [COORD_BITS-1:0]          height_ff;
   logic                           last_ff;
   logic                           rsp_v_ff, rsp_v_in;
   logic [lds_pkg::DIR_BITS-1:0]   rsp_dir_ff;

   logic                           req_xfer;
   logic                           fire;
   logic                           emit;
   logic [lds_pkg::DIR_BITS-1:0]   dir;

   assign csr_ready = 1'b1;

   lds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // process the held item unless a result is stuck on the output
   assign fire      = in_v_ff && !(rsp_v_ff && rsp_stall);
   assign req_stall = in_v_ff && !fire;
   assign req_xfer  = req_valid && !req_stall;

   lds_core #(
      .COORD_BITS (COORD_BITS),
      .TICK_BITS  (TICK_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .cfg           (cfg),
      .action        (action_ff),
      .object_class  (class_ff),
      .box_left      (left_ff),
      .box_top       (top_ff),
      .box_width     (width_ff),
      .box_height    (height_ff),
      .last_in_frame (last_ff),
      .emit          (emit),
      .direction     (dir)
   );

   always_comb begin
      in_v_in = in_v_ff;
      if (req_xfer) begin
         in_v_in = 1'b1;
      end else if (fire) begin
         in_v_in = 1'b0;
      end
   end

   always_comb begin
      rsp_v_in = rsp_v_ff;
      if (fire) begin
         rsp_v_in = emit;
      end else if (rsp_v_ff && !rsp_stall) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         action_ff <= req_action;
         class_ff  <= req_object_class;
         left_ff   <= req_box_left;
         top_ff    <= req_box_top;
         width_ff  <= req_box_width;
         height_ff <= req_box_height;
         last_ff   <= req_last_in_frame;
      end
      if (emit) begin
         rsp_dir_ff <= dir;
      end
   end

   assign rsp_valid     = rsp_v_ff;
   assign rsp_direction = rsp_dir_ff;

endmodule

@@ rtl/lds_checker.sv @@
module lds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [lds_pkg::DIR_BITS-1:0] rsp_direction,
   input logic                         csr_ready
);

   // held result keeps its direction until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_direction))
      else $error("result changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("handshake not cleared by reset");

   // input only backs up behind a stuck result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled with output free");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      req_valid || !req_valid |-> csr_ready)
      else $error("register port refused a write");

endmodule

bind largest_box_deadzone_steering lds_checker u_lds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_direction (rsp_direction),
   .csr_ready     (csr_ready)
);

@@ verif/tb_largest_box_deadzone_steering.sv @@
module tb_largest_box_deadzone_steering;

   localparam int COORD_BITS      = 12;
   localparam int TICK_BITS       = 16;
   localparam int DRAIN_CYCLES    = 4;
   localparam int PRESSURE_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef logic [COORD_BITS-1:0]                            coord_type;
   typedef logic [lds_pkg::CLASS_BITS-1:0]                   class_type;
   typedef logic [lds_pkg::CFG_BITS-1:0]                     cfg_word_type;
   typedef logic [lds_pkg::INTERVAL_BITS-1:0]                gap_type;
   typedef logic [lds_pkg::DIR_BITS-1:0]                     dir_type;
   typedef logic [lds_pkg::CSR_IDX_BITS-1:0]                 csr_idx_type;
   typedef logic [lds_pkg::CSR_DATA_BITS-1:0]                csr_data_type;
   typedef logic [lds_pkg::CSR_DATA_BITS-lds_pkg::CFG_BITS-1:0] junk_type;

   typedef struct packed {
      logic      action;
      class_type object_class;
      coord_type box_left;
      coord_type box_top;
      coord_type box_width;
      coord_type box_height;
      logic      last_in_frame;
   } steer_item_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic         req_action;
   class_type    req_object_class;
   coord_type    req_box_left;
   coord_type    req_box_top;
   coord_type    req_box_width;
   coord_type    req_box_height;
   logic         req_last_in_frame;
   logic         rsp_valid;
   logic         rsp_stall;
   dir_type      rsp_direction;
   logic         csr_valid;
   logic         csr_ready;
   csr_idx_type  csr_index;
   csr_data_type csr_data;

   largest_box_deadzone_steering #(
      .COORD_BITS(COORD_BITS),
      .TICK_BITS (TICK_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_object_class (req_object_class),
      .req_box_left     (req_box_left),
      .req_box_top      (req_box_top),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_last_in_frame(req_last_in_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_direction    (rsp_direction),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   steer_item_type pending_items[$];
   dir_type        expected_dirs[$];
   int             fail_count = 0;
   int             stuck_cycles = 0;
   logic           req_taken = 1'b0;
   int             req_gap = 0;
   int             req_calm = 0;
   int             rsp_hold = 0;
   int             rsp_calm = 0;
   logic           tail_quiet = 1'b0;
   logic           pressure_armed = 1'b0;
   logic           pressure_done = 1'b0;

   // tracker mirror
   cfg_word_type            ref_cx;
   cfg_word_type            ref_cy;
   cfg_word_type            zone_h;
   cfg_word_type            zone_v;
   gap_type                 min_gap;
   logic [2*COORD_BITS-1:0] track_area;
   coord_type               track_left;
   coord_type               track_top;
   coord_type               track_width;
   coord_type               track_height;
   logic                    have_person;
   logic [TICK_BITS-1:0]    tick_count;

   function automatic void add_item(input steer_item_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic void add_dir(input dir_type d);
      expected_dirs.insert(expected_dirs.size(), d);
   endfunction

   function automatic void track_item(input steer_item_type it);
      logic [2*COORD_BITS-1:0] area;
      int cx2, cy2, rx2, ry2, dx2, dy2;
      if (it.action == lds_pkg::ACTION_TICK) begin
         if (tick_count != '1) tick_count++;
         return;
      end
      if (it.object_class == lds_pkg::CLASS_PERSON) begin
         area = it.box_width * it.box_height;
         if (!have_person || area > track_area) begin
            track_area   = area;
            track_left   = it.box_left;
            track_top    = it.box_top;
            track_width  = it.box_width;
            track_height = it.box_height;
            have_person  = 1'b1;
         end
      end
      if (it.last_in_frame) begin
         if (have_person && tick_count >= min_gap) begin
            tick_count = '0;
            cx2 = 2 * int'(track_left) + int'(track_width);
            cy2 = 2 * int'(track_top) + int'(track_height);
            rx2 = 2 * int'(ref_cx);
            ry2 = 2 * int'(ref_cy);
            dx2 = 2 * int'(zone_h);
            dy2 = 2 * int'(zone_v);
            if (cx2 > rx2 + dx2) add_dir(lds_pkg::DIR_RIGHT);
            else if (cx2 < rx2 - dx2) add_dir(lds_pkg::DIR_LEFT);
            else if (cy2 < ry2 - dy2) add_dir(lds_pkg::DIR_UP);
            else if (cy2 > ry2 + dy2) add_dir(lds_pkg::DIR_DOWN);
         end
         track_area  = '0;
         have_person = 1'b0;
      end
   endfunction

   function automatic steer_item_type make_box(input class_type cls,
                                               input coord_type l, t, w, h,
                                               input logic last);
      steer_item_type it;
      it = '{lds_pkg::ACTION_BOX, cls, l, t, w, h, last};
      return it;
   endfunction

   function automatic steer_item_type make_tick();
      logic [63:0] raw;
      steer_item_type it;
      raw = {$urandom, $urandom};
      it = raw[$bits(steer_item_type)-1:0];
      it.action = lds_pkg::ACTION_TICK;
      return it;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 3))
         0: return coord_type'($urandom_range(0, 15));
         1: return coord_type'($urandom_range(4080, 4095));
         default: return coord_type'($urandom_range(0, 4095));
      endcase
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_calm > 0) req_calm--;
         else if ($urandom_range(0, 99) == 0) req_calm = $urandom_range(20, 150);
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!tail_quiet && req_calm == 0 && $urandom_range(0, 11) == 0) begin
               req_gap = $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               steer_item_type nxt;
               nxt = pending_items.pop_front();
               req_action        <= nxt.action;
               req_object_class  <= nxt.object_class;
               req_box_left      <= nxt.box_left;
               req_box_top       <= nxt.box_top;
               req_box_width     <= nxt.box_width;
               req_box_height    <= nxt.box_height;
               req_last_in_frame <= nxt.last_in_frame;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_calm > 0) rsp_calm--;
         else if ($urandom_range(0, 99) == 0) rsp_calm = $urandom_range(20, 150);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (pressure_armed && !pressure_done) begin
            pressure_done = 1'b1;
            rsp_hold = PRESSURE_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (!tail_quiet && rsp_calm == 0 && $urandom_range(0, 9) == 0) begin
            rsp_hold = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      dir_type want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_dirs.size() == 0) begin
               $display("%0t: direction transfer with none pending, expected none, actual %0d",
                        $time, rsp_direction);
               fail_count++;
            end else begin
               want = expected_dirs.pop_front();
               if (rsp_direction !== want) begin
                  $display("%0t: direction mismatch, expected %0d, actual %0d",
                           $time, want, rsp_direction);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            track_item('{req_action, req_object_class, req_box_left, req_box_top,
                         req_box_width, req_box_height, req_last_in_frame});
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lds_pkg::CSR_REF_X:        ref_cx  = csr_data[lds_pkg::CFG_BITS-1:0];
               lds_pkg::CSR_REF_Y:        ref_cy  = csr_data[lds_pkg::CFG_BITS-1:0];
               lds_pkg::CSR_DEADZONE_H:   zone_h  = csr_data[lds_pkg::CFG_BITS-1:0];
               lds_pkg::CSR_DEADZONE_V:   zone_v  = csr_data[lds_pkg::CFG_BITS-1:0];
               lds_pkg::CSR_MIN_INTERVAL: min_gap = csr_data[lds_pkg::INTERVAL_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // entered and left at a falling edge
   task automatic wait_idle();
      @(posedge clock);
      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      @(negedge clock);
      while (expected_dirs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx,
                            input csr_data_type data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_steering(input cfg_word_type cx, cy, dzh, dzv,
                               input gap_type gap);
      junk_type junk;
      junk = junk_type'($urandom);
      write_csr(lds_pkg::CSR_REF_X, {junk, cx});
      junk = junk_type'($urandom);
      write_csr(lds_pkg::CSR_REF_Y, {junk, cy});
      junk = junk_type'($urandom);
      write_csr(lds_pkg::CSR_DEADZONE_H, {junk, dzh});
      junk = junk_type'($urandom);
      write_csr(lds_pkg::CSR_DEADZONE_V, {junk, dzv});
      write_csr(lds_pkg::CSR_MIN_INTERVAL, gap);
      write_csr(csr_idx_type'(lds_pkg::CSR_MIN_INTERVAL + 1 + $urandom_range(0, 2)),
                csr_data_type'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_frames(input int target);
      int             added;
      int             boxes;
      logic [63:0]    raw;
      steer_item_type it;
      coord_type      prev_w, prev_h;
      added  = 0;
      prev_w = 0;
      prev_h = 0;
      while (added < target) begin
         if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom, $urandom};
            it = raw[$bits(steer_item_type)-1:0];
            add_item(it);
            added++;
         end else begin
            boxes = $urandom_range(1, 5);
            for (int b = 0; b < boxes; b++) begin
               while ($urandom_range(0, 3) == 0) begin
                  add_item(make_tick());
                  added++;
               end
               it = make_box(class_type'(($urandom_range(0, 3) == 0) ?
                                         $urandom_range(1, 255) : lds_pkg::CLASS_PERSON),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             b == boxes - 1);
               // equal areas now and then
               if (b > 0 && $urandom_range(0, 7) == 0) begin
                  it.box_width  = prev_w;
                  it.box_height = prev_h;
               end
               prev_w = it.box_width;
               prev_h = it.box_height;
               add_item(it);
               added++;
            end
         end
      end
   endtask

   task automatic run_random_phase(input cfg_word_type cx, cy, dzh, dzv,
                                   input gap_type gap,
                                   input int count, input logic quiet);
      wait_idle();
      set_steering(cx, cy, dzh, dzv, gap);
      @(posedge clock);
      tail_quiet = quiet;
      queue_random_frames(count);
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = lds_pkg::ACTION_BOX;
      req_object_class  = lds_pkg::CLASS_PERSON;
      req_box_left      = '0;
      req_box_top       = '0;
      req_box_width     = '0;
      req_box_height    = '0;
      req_last_in_frame = 1'b0;
      rsp_stall         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = lds_pkg::CSR_REF_X;
      csr_data          = '0;
      ref_cx            = lds_pkg::REF_X_RESET;
      ref_cy            = lds_pkg::REF_Y_RESET;
      zone_h            = lds_pkg::DEADZONE_H_RESET;
      zone_v            = lds_pkg::DEADZONE_V_RESET;
      min_gap           = lds_pkg::MIN_INTERVAL_RESET;
      track_area        = '0;
      track_left        = '0;
      track_top         = '0;
      track_width       = '0;
      track_height      = '0;
      have_person       = 1'b0;
      tick_count        = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset interval not yet met
      @(posedge clock);
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 0, 0, 0, 1'b1));
      wait_idle();
      write_csr(lds_pkg::CSR_MIN_INTERVAL, 16'd0);
      csr_valid <= 1'b0;

      // reset centre and deadzones, decision on every frame with a person
      @(posedge clock);
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 500, 0, 80, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 4095, 500, 4095, 80, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 900, 500, 120, 80, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 900, 0, 120, 0, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 900, 4095, 120, 4095, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 1110, 500, 0, 80, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 1110, 500, 1, 80, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 810, 500, 0, 80, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 809, 500, 1, 80, 1'b1));
      add_item(make_box(8'd255, 0, 0, 4095, 4095, 1'b1));
      // largest person wins, tie keeps the earlier box
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 500, 10, 10, 1'b0));
      add_item(make_box(8'd1, 4000, 0, 95, 4095, 1'b0));
      add_item(make_box(lds_pkg::CLASS_PERSON, 3000, 490, 100, 100, 1'b0));
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 490, 100, 100, 1'b1));
      // non-person box closes the frame
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 530, 20, 20, 1'b0));
      add_item(make_box(8'd7, 4095, 4095, 4095, 4095, 1'b1));
      // tick carrying last_in_frame does not close the frame
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 515, 50, 50, 1'b0));
      begin
         steer_item_type tk;
         tk = make_tick();
         tk.last_in_frame = 1'b1;
         tk.object_class  = lds_pkg::CLASS_PERSON;
         add_item(tk);
      end
      add_item(make_box(lds_pkg::CLASS_PERSON, 960, 540, 1, 1, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 0, 4095, 4095, 1'b1));
      wait_idle();
      write_csr(lds_pkg::CSR_MIN_INTERVAL, 16'd3);
      csr_valid <= 1'b0;

      // rate limit held, then met; inside-deadzone decision restarts the count
      @(posedge clock);
      add_item(make_tick());
      add_item(make_tick());
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 500, 0, 80, 1'b1));
      add_item(make_tick());
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 500, 0, 80, 1'b1));
      repeat (3) add_item(make_tick());
      add_item(make_box(lds_pkg::CLASS_PERSON, 900, 500, 120, 80, 1'b1));
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 500, 0, 80, 1'b1));

      run_random_phase(0, 0, 0, 0, 0, 210, 1'b0);
      run_random_phase(4095, 4095, 4095, 4095, 1, 210, 1'b0);
      run_random_phase(100, 60, 200, 150, 2, 210, 1'b0);

      // fill the block while results are held off
      wait_idle();
      set_steering(960, 540, 150, 100, 0);
      @(posedge clock);
      pressure_armed = 1'b1;
      repeat (60) add_item(make_box(lds_pkg::CLASS_PERSON, coord_type'(rand_coord() % 64), 500,
                                    coord_type'($urandom_range(0, 63)), 80, 1'b1));

      // interval far above the tick count, no decision
      wait_idle();
      set_steering(960, 540, 150, 100, 16'hFFFF);
      @(posedge clock);
      repeat (5) add_item(make_tick());
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 500, 0, 80, 1'b1));
      repeat (2) add_item(make_tick());
      add_item(make_box(lds_pkg::CLASS_PERSON, 0, 500, 0, 80, 1'b1));

      run_random_phase(cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 600)),
                       cfg_word_type'($urandom_range(0, 600)),
                       gap_type'($urandom_range(0, 3)), 210, 1'b0);
      run_random_phase(cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 4095)),
                       gap_type'($urandom_range(500, 2000)), 210, 1'b0);
      run_random_phase(cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 300)),
                       cfg_word_type'($urandom_range(0, 300)), 0, 210, 1'b0);
      run_random_phase(cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 4095)),
                       cfg_word_type'($urandom_range(0, 400)),
                       cfg_word_type'($urandom_range(0, 400)),
                       gap_type'($urandom_range(0, 2)), 100, 1'b1);
      wait_idle();

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lds_pkg.sv
rtl/lds_csr.sv
rtl/lds_core.sv
rtl/largest_box_deadzone_steering.sv
rtl/lds_checker.sv
verif/tb_largest_box_deadzone_steering.sv
